// ----- sv/hwpl_pkg.sv -----
`timescale 1ns / 1ps
package hwpl_pkg;

  // Defaults for the top level parameters.
  localparam int MAX_LEAVES_DEF  = 64;
  localparam int WEIGHT_BITS_DEF = 16;

  // Fixed field widths of the two channels.
  localparam int LEAF_FIELD_BITS = 16;
  localparam int PATH_BITS       = 28;

  localparam logic [PATH_BITS-1:0] PATH_MAX = {PATH_BITS{1'b1}};

endpackage

// ----- sv/hwpl_cell.sv -----
`timescale 1ns / 1ps
module hwpl_cell #(
  parameter int W = 22
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         shift,
  input  logic         carry_in_v,
  input  logic [W-1:0] carry_in_w,
  input  logic         right_v,
  input  logic [W-1:0] right_w,
  output logic         held_v,
  output logic [W-1:0] held_w,
  output logic         carry_out_v,
  output logic [W-1:0] carry_out_w
);

  // Each cell keeps the smaller of its own weight and the one arriving from
  // the left and hands the larger one on to the right in the next cycle.
  // A shift pulls every held weight one cell toward the head of the row.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_v      <= 1'b0;
      carry_out_v <= 1'b0;
    end else if (shift) begin
      held_v      <= right_v;
      held_w      <= right_w;
      carry_out_v <= 1'b0;
    end else if (carry_in_v) begin
      if (!held_v || (carry_in_w < held_w)) begin
        held_v      <= 1'b1;
        held_w      <= carry_in_w;
        carry_out_v <= held_v;
        carry_out_w <= held_w;
      end else begin
        carry_out_v <= 1'b1;
        carry_out_w <= carry_in_w;
      end
    end else begin
      carry_out_v <= 1'b0;
    end
  end

endmodule

// ----- sv/huffman_weighted_path_length.sv -----
`timescale 1ns / 1ps
// A set of leaves is taken while collecting, then the row settles, then each merge
// pops the two head nodes and lets the new node settle, and the result posts once
// the last merge has settled. Each settle wait is set by the ripple of a new node
// down the row of MAX_LEAVES sorting cells; no leaf is taken until the result posts.
// Reset (rst, synchronous, active high) empties the cell row, clears the leaf
// count and path length sum, and drops any pending result.
module huffman_weighted_path_length #(
  parameter int MAX_LEAVES  = hwpl_pkg::MAX_LEAVES_DEF,
  parameter int WEIGHT_BITS = hwpl_pkg::WEIGHT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                leaf_valid,
  output logic                                leaf_stall,
  input  logic [hwpl_pkg::LEAF_FIELD_BITS-1:0] leaf_weight,
  input  logic                                last_leaf,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [hwpl_pkg::PATH_BITS-1:0]      path_length
);

  import hwpl_pkg::*;

  // Only the low WEIGHT_BITS bits of a leaf count, and no more than the field.
  localparam int LEAF_BITS = (WEIGHT_BITS < LEAF_FIELD_BITS) ? WEIGHT_BITS : LEAF_FIELD_BITS;
  // A merged node never exceeds the sum of all leaves.
  localparam int NODE_BITS = LEAF_BITS + $clog2(MAX_LEAVES);
  localparam int ACC_BITS  = ((NODE_BITS > PATH_BITS) ? NODE_BITS : PATH_BITS) + 1;
  localparam int LIVE_BITS = $clog2(MAX_LEAVES + 1);
  localparam int CNT_BITS  = $clog2(MAX_LEAVES + 1);

  localparam logic [2:0] S_COLLECT = 3'd0;
  localparam logic [2:0] S_SETTLE  = 3'd1;
  localparam logic [2:0] S_POP_A   = 3'd2;
  localparam logic [2:0] S_POP_B   = 3'd3;
  localparam logic [2:0] S_FINISH  = 3'd4;

  logic [2:0]           state;
  logic [LIVE_BITS-1:0] live;
  logic [CNT_BITS-1:0]  settle_cnt;
  logic [PATH_BITS-1:0] length_sum;
  logic [NODE_BITS-1:0] first_w;
  logic                 inject_v;
  logic [NODE_BITS-1:0] inject_w;

  // The cell row. Index 0 is the head and always holds the smallest weight
  // once the row has settled. The held entry past the tail reads as empty,
  // and the carry past the tail must never become valid.
  logic                 held_v  [0:MAX_LEAVES];
  logic [NODE_BITS-1:0] held_w  [0:MAX_LEAVES];
  logic                 carry_v [0:MAX_LEAVES];
  logic [NODE_BITS-1:0] carry_w [0:MAX_LEAVES];
  logic                 shift;

  logic                 leaf_take;
  logic                 post;
  logic [NODE_BITS-1:0] merge_w;
  logic [ACC_BITS-1:0]  acc_wide;

  assign held_v[MAX_LEAVES] = 1'b0;
  assign held_w[MAX_LEAVES] = '0;
  assign carry_v[0]         = inject_v;
  assign carry_w[0]         = inject_w;

  for (genvar i = 0; i < MAX_LEAVES; i++) begin : g_cell
    hwpl_cell #(
      .W(NODE_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .shift      (shift),
      .carry_in_v (carry_v[i]),
      .carry_in_w (carry_w[i]),
      .right_v    (held_v[i+1]),
      .right_w    (held_w[i+1]),
      .held_v     (held_v[i]),
      .held_w     (held_w[i]),
      .carry_out_v(carry_v[i+1]),
      .carry_out_w(carry_w[i+1])
    );
  end

  // Leaves are taken every cycle while collecting. Each one enters the head
  // of the row and sinks to its sorted place while the next one follows.
  assign leaf_stall = (state != S_COLLECT);
  assign leaf_take  = leaf_valid && !leaf_stall;

  // The result register frees up when its transaction completes, so a
  // finished set can post as soon as the previous result is taken.
  assign post = (state == S_FINISH) && (!result_valid || !result_stall);

  // Two pops take the two smallest nodes; the root is shifted out on post
  // so the row is empty for the next set.
  assign shift = (state == S_POP_A) || (state == S_POP_B) || post;

  assign merge_w  = first_w + held_w[0];
  assign acc_wide = ACC_BITS'(length_sum) + ACC_BITS'(merge_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_COLLECT;
      live         <= '0;
      settle_cnt   <= '0;
      length_sum   <= '0;
      inject_v     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      inject_v <= 1'b0;

      if (post) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_COLLECT: begin
          if (leaf_take) begin
            // Leaves past the row capacity are dropped; the closing flag
            // still starts the build.
            if (live < LIVE_BITS'(MAX_LEAVES)) begin
              inject_v <= 1'b1;
              inject_w <= NODE_BITS'(leaf_weight[LEAF_BITS-1:0]);
              live     <= live + LIVE_BITS'(1);
            end
            if (last_leaf) begin
              state      <= S_SETTLE;
              settle_cnt <= CNT_BITS'(MAX_LEAVES);
            end
          end
        end
        S_SETTLE: begin
          if (settle_cnt == '0) begin
            state <= (live >= LIVE_BITS'(2)) ? S_POP_A : S_FINISH;
          end else begin
            settle_cnt <= settle_cnt - CNT_BITS'(1);
          end
        end
        S_POP_A: begin
          first_w <= held_w[0];
          state   <= S_POP_B;
        end
        S_POP_B: begin
          inject_v   <= 1'b1;
          inject_w   <= merge_w;
          live       <= live - LIVE_BITS'(1);
          length_sum <= (acc_wide > ACC_BITS'(PATH_MAX)) ? PATH_MAX
                                                         : acc_wide[PATH_BITS-1:0];
          settle_cnt <= CNT_BITS'(MAX_LEAVES);
          state      <= S_SETTLE;
        end
        S_FINISH: begin
          if (post) begin
            path_length <= length_sum;
            length_sum  <= '0;
            live        <= '0;
            state       <= S_COLLECT;
          end
        end
        default: begin
          state <= S_COLLECT;
        end
      endcase
    end
  end

  // A weight sinking down the row always finds room before the tail.
  a_no_tail_overflow: assert property (@(posedge clk) disable iff (rst)
    !carry_v[MAX_LEAVES])
    else $error("weight carried past the tail of the cell row");

  // Both popped nodes are present when a merge starts.
  a_pop_pair_present: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP_A) |-> (held_v[0] && held_v[1]))
    else $error("merge started with fewer than two nodes in the row");

  // The settled row delivers its two smallest weights at the head, in order.
  a_pop_pair_sorted: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP_A) |-> (held_w[0] <= held_w[1]))
    else $error("head of the cell row is out of order");

  // The second pop sees the node that followed the first one.
  a_pop_b_follows: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP_B) |-> ($past(state) == S_POP_A) && held_v[0])
    else $error("second pop without a preceding first pop");

  // The node count never exceeds the row.
  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live <= LIVE_BITS'(MAX_LEAVES))
    else $error("node count exceeds the cell row");

endmodule

// ----- tb/sv/huffman_weighted_path_length_checker.sv -----
`timescale 1ns / 1ps
module huffman_weighted_path_length_checker #(
  parameter int MAX_LEAVES  = hwpl_pkg::MAX_LEAVES_DEF,
  parameter int WEIGHT_BITS = hwpl_pkg::WEIGHT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 leaf_valid,
  input  logic                                 leaf_stall,
  input  logic [hwpl_pkg::LEAF_FIELD_BITS-1:0] leaf_weight,
  input  logic                                 last_leaf,
  input  logic                                 result_valid,
  input  logic                                 result_stall,
  input  logic [hwpl_pkg::PATH_BITS-1:0]       path_length,
  output int                                   errors,
  output int                                   pending
);

  import hwpl_pkg::*;

  localparam int NODE_DEPTH = 2 * MAX_LEAVES - 1;
  localparam int NODE_BITS  = WEIGHT_BITS + $clog2(MAX_LEAVES) + 1;
  localparam logic [LEAF_FIELD_BITS-1:0] WEIGHT_MASK =
    (WEIGHT_BITS >= LEAF_FIELD_BITS) ? '1 : LEAF_FIELD_BITS'((1 << WEIGHT_BITS) - 1);

  logic [NODE_BITS-1:0] node_wt [NODE_DEPTH];
  bit                   node_used [NODE_DEPTH];
  int                   set_size;
  logic [PATH_BITS-1:0] path_due [$];
  logic [PATH_BITS-1:0] want;
  int                   k;

  // Builds the tree over the first n nodes and returns the sum of all merge
  // results, saturated to the path length field.
  function automatic logic [PATH_BITS-1:0] tree_cost(input int n);
    int                   top;
    int                   i;
    int                   a;
    int                   b;
    bit                   have_a;
    bit                   have_b;
    logic [NODE_BITS-1:0] s;
    logic [PATH_BITS:0]   acc;
    acc = '0;
    if (n < 2) return '0;
    for (top = n; top < 2 * n - 1; top++) begin
      have_a = 1'b0;
      have_b = 1'b0;
      a = 0;
      b = 0;
      for (i = 0; i < top; i++) begin
        if (!node_used[i]) begin
          if (!have_a || node_wt[i] < node_wt[a]) begin
            b = a;
            have_b = have_a;
            a = i;
            have_a = 1'b1;
          end else if (!have_b || node_wt[i] < node_wt[b]) begin
            b = i;
            have_b = 1'b1;
          end
        end
      end
      node_used[a] = 1'b1;
      node_used[b] = 1'b1;
      s = node_wt[a] + node_wt[b];
      node_wt[top] = s;
      acc = acc + (PATH_BITS + 1)'(s);
      if (acc > {1'b0, PATH_MAX}) acc = {1'b0, PATH_MAX};
    end
    return acc[PATH_BITS-1:0];
  endfunction

  initial begin
    errors = 0;
    pending = 0;
    set_size = 0;
    for (k = 0; k < NODE_DEPTH; k++) begin
      node_wt[k] = '0;
      node_used[k] = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      path_due.delete();
      set_size = 0;
      for (k = 0; k < NODE_DEPTH; k++) node_used[k] = 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (path_due.size() == 0) begin
          $display("%0t: unexpected path_length transaction, expected none, actual %0d",
                   $time, path_length);
          errors++;
        end else begin
          want = path_due.pop_front();
          if (path_length !== want) begin
            $display("%0t: path_length mismatch, expected %0d, actual %0d",
                     $time, want, path_length);
            errors++;
          end
        end
      end
      if (leaf_valid && !leaf_stall) begin
        // Leaves beyond the store capacity are dropped, but the closing flag
        // still counts.
        if (set_size < MAX_LEAVES) begin
          node_wt[set_size] = NODE_BITS'(leaf_weight & WEIGHT_MASK);
          node_used[set_size] = 1'b0;
          set_size++;
        end
        if (last_leaf) begin
          path_due.push_back(tree_cost(set_size));
          set_size = 0;
          for (k = 0; k < NODE_DEPTH; k++) node_used[k] = 1'b0;
        end
      end
    end
    pending = path_due.size();
  end

endmodule

// ----- tb/sv/huffman_weighted_path_length_tb.sv -----
`timescale 1ns / 1ps
module huffman_weighted_path_length_tb;
  import hwpl_pkg::*;

  // Number of counted leaves in the random part, and the point after which
  // both sides stop idling so the tail of the run goes at full rate.
  localparam int LEAF_GOAL   = 900;
  localparam int CALM_POINT  = 800;
  // The limit lies well above the slowest correct run, which is set by the settle
  // wait of each merge plus the idle bursts on both channels.
  localparam int CYCLE_LIMIT = 1000000;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       leaf_valid;
  logic                       leaf_stall;
  logic [LEAF_FIELD_BITS-1:0] leaf_weight;
  logic                       last_leaf;
  logic                       result_valid;
  logic                       result_stall;
  logic [PATH_BITS-1:0]       path_length;

  int errors;
  int pending;
  int leaves_counted;
  int cycles;
  bit calm;

  huffman_weighted_path_length u_top (
    .clk          (clk),
    .rst          (rst),
    .leaf_valid   (leaf_valid),
    .leaf_stall   (leaf_stall),
    .leaf_weight  (leaf_weight),
    .last_leaf    (last_leaf),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .path_length  (path_length)
  );

  // The checker watches both channels, keeps its own copy of the node store
  // and compares every result transaction against the oldest prediction.
  huffman_weighted_path_length_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .leaf_valid   (leaf_valid),
    .leaf_stall   (leaf_stall),
    .leaf_weight  (leaf_weight),
    .last_leaf    (last_leaf),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .path_length  (path_length),
    .errors       (errors),
    .pending      (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Picks a leaf weight. Mode 0 is the full range, mode 1 a tiny range so
  // that ties are common, mode 2 the extremes, and mode 3 a random width so
  // that small and mid-sized weights mix.
  function automatic logic [LEAF_FIELD_BITS-1:0] pick_weight(input int mode);
    logic [LEAF_FIELD_BITS-1:0] w;
    w = LEAF_FIELD_BITS'($urandom);
    case (mode)
      1: begin
        w = LEAF_FIELD_BITS'($urandom_range(0, 3));
      end
      2: begin
        case ($urandom_range(0, 3))
          0: w = '0;
          1: w = '1;
          2: w = {1'b1, {(LEAF_FIELD_BITS-1){1'b0}}};
          default: w = LEAF_FIELD_BITS'(1);
        endcase
      end
      3: begin
        w = w >> $urandom_range(0, LEAF_FIELD_BITS - 1);
      end
      default: begin
      end
    endcase
    return w;
  endfunction

  // Sends one leaf transaction. It is entered at a falling edge and returns
  // at the falling edge after the transaction was accepted, with valid still
  // high so a following leaf can go out back to back. An idle burst, when
  // one is taken, drops valid first and so always lands in a different step
  // from the next raise.
  task automatic send_leaf(input logic [LEAF_FIELD_BITS-1:0] w, input bit last,
                           input bit gappy);
    if (gappy && !calm && $urandom_range(0, 3) == 0) begin
      leaf_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    leaf_valid  <= 1'b1;
    leaf_weight <= w;
    last_leaf   <= last;
    @(posedge clk);
    while (leaf_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Sends a whole set of n leaves with the closing flag on the last one.
  // Only leaves that fit in the node store count toward the goal, since the
  // block drops the rest.
  task automatic send_set(input int n, input int mode, input bit gappy);
    int i;
    for (i = 0; i < n; i++) begin
      send_leaf(pick_weight(mode), i == n - 1, gappy);
      if (i < MAX_LEAVES_DEF) leaves_counted++;
      if (leaves_counted > CALM_POINT) calm = 1'b1;
    end
  endtask

  // Result side: stall bursts alternate with free
  // stretches, and once the run is calm the receiver never stalls.
  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        result_stall <= 1'b0;
      end else begin
        repeat ($urandom_range(0, 40)) @(negedge clk);
      end
    end
  end

  // Watchdog on the cycle count; a hung block ends the run as a failure.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int size;
    int pick;
    rst            = 1'b1;
    leaf_valid     = 1'b0;
    leaf_weight    = '0;
    last_leaf      = 1'b0;
    leaves_counted = 0;
    calm           = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed sets. A single leaf, at either extreme, must give zero.
    send_leaf('1, 1'b1, 1'b0);
    send_leaf('0, 1'b1, 1'b0);
    // Two leaves at opposite extremes.
    send_leaf('0, 1'b0, 1'b0);
    send_leaf('1, 1'b1, 1'b0);
    // Three equal maximum weights, so the first merge is decided by a tie.
    send_leaf('1, 1'b0, 1'b0);
    send_leaf('1, 1'b0, 1'b0);
    send_leaf('1, 1'b1, 1'b0);
    // All zero weights.
    send_leaf('0, 1'b0, 1'b0);
    send_leaf('0, 1'b0, 1'b0);
    send_leaf('0, 1'b1, 1'b0);
    // A skewed set where a merged node ties with a remaining leaf.
    send_leaf(16'd1, 1'b0, 1'b0);
    send_leaf(16'd1, 1'b0, 1'b0);
    send_leaf(16'd2, 1'b0, 1'b0);
    send_leaf(16'd4, 1'b0, 1'b0);
    send_leaf(16'd8, 1'b1, 1'b0);
    // Mixed weights given in descending order.
    send_leaf(16'hffff, 1'b0, 1'b0);
    send_leaf(16'h8000, 1'b0, 1'b0);
    send_leaf(16'h00ff, 1'b0, 1'b0);
    send_leaf(16'h0003, 1'b0, 1'b0);
    send_leaf(16'h0000, 1'b1, 1'b0);

    // Random sets. Most are small; some fill a good part of the store, and a
    // few reach or pass the store capacity so that extra leaves are dropped
    // and the closing flag arrives on an ignored leaf.
    while (leaves_counted < LEAF_GOAL) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        size = $urandom_range(MAX_LEAVES_DEF, MAX_LEAVES_DEF + 6);
      end else if (pick <= 3) begin
        size = $urandom_range(9, MAX_LEAVES_DEF - 1);
      end else begin
        size = $urandom_range(1, 8);
      end
      send_set(size, $urandom_range(0, 3), $urandom_range(0, 2) != 0);
    end
    leaf_valid <= 1'b0;

    // Let every predicted result arrive, then give the block time to show
    // any spurious extra transaction.
    while (pending != 0) @(posedge clk);
    repeat (2 * MAX_LEAVES_DEF + 8) @(posedge clk);

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
